// File: sv/gbsp_pkg.sv
// ----------------------------------------------------------------------------
// gbsp_pkg: shared types and constants of the GIF block structure parser
// Holds the phase encoding, the section codes and the structs that carry
// parser state and tagged words between the modules.
// ----------------------------------------------------------------------------
package gbsp_pkg;

  localparam logic [7:0] TRAILER_BYTE   = 8'h3B;
  localparam int unsigned TABLE_FLAG_BIT = 7;
  localparam logic [9:0] OFFSET_LIMIT   = 10'd767;

  // Section codes as they appear on the result channel.
  localparam logic [3:0] SEC_SIG      = 4'd0;
  localparam logic [3:0] SEC_SCREEN   = 4'd1;
  localparam logic [3:0] SEC_GTABLE   = 4'd2;
  localparam logic [3:0] SEC_SEP      = 4'd3;
  localparam logic [3:0] SEC_IMGDESC  = 4'd4;
  localparam logic [3:0] SEC_LTABLE   = 4'd5;
  localparam logic [3:0] SEC_CODESIZE = 4'd6;
  localparam logic [3:0] SEC_BLKLEN   = 4'd7;
  localparam logic [3:0] SEC_BLKDATA  = 4'd8;
  localparam logic [3:0] SEC_TRAILER  = 4'd9;
  localparam logic [3:0] SEC_AFTER    = 4'd10;

  // Parser phase, one-hot. The trailer is never a resting phase: the
  // trailer byte is seen in the separator phase and moves straight on.
  typedef enum logic [9:0] {
    PH_SIG      = 10'b00_0000_0001,
    PH_SCREEN   = 10'b00_0000_0010,
    PH_GTABLE   = 10'b00_0000_0100,
    PH_SEP      = 10'b00_0000_1000,
    PH_IMGDESC  = 10'b00_0001_0000,
    PH_LTABLE   = 10'b00_0010_0000,
    PH_CODESIZE = 10'b00_0100_0000,
    PH_BLKLEN   = 10'b00_1000_0000,
    PH_BLKDATA  = 10'b01_0000_0000,
    PH_AFTER    = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [9:0]  count;
    logic [9:0]  table_bytes;
    logic [7:0]  held_flags;
    logic [7:0]  block_remaining;
  } state_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [3:0] section;
    logic [9:0] offset_in_section;
    logic       end_of_file;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:           PH_SIG,
    count:           10'd0,
    table_bytes:     10'd0,
    held_flags:      8'd0,
    block_remaining: 8'd0
  };

endpackage

// File: sv/gbsp_in_if.sv
// ----------------------------------------------------------------------------
// gbsp_in_if: byte channel into the GIF block structure parser
// Valid/ready channel carrying one stream byte and its restart mark.
// ----------------------------------------------------------------------------
interface gbsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink (input valid, input data_byte, input restart, output ready);
endinterface

// File: sv/gbsp_out_if.sv
// ----------------------------------------------------------------------------
// gbsp_out_if: tag channel out of the GIF block structure parser
// Valid/ready channel carrying one byte with its section tag.
// ----------------------------------------------------------------------------
interface gbsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic [3:0] section;
  logic [9:0] offset_in_section;
  logic       end_of_file;

  modport source (
    output valid, output byte_out, output section, output offset_in_section,
    output end_of_file, input ready
  );
  modport sink (
    input valid, input byte_out, input section, input offset_in_section,
    input end_of_file, output ready
  );
endinterface

// File: sv/gbsp_tagger.sv
// ----------------------------------------------------------------------------
// gbsp_tagger: next-state and tag logic of the parser
// From the current parser state and one stream byte, works out the tag of
// that byte and the state that follows it.
// ----------------------------------------------------------------------------
module gbsp_tagger (
  input  gbsp_pkg::state_t  state,
  input  logic [7:0]        data_byte,
  input  logic              restart,
  output gbsp_pkg::state_t  state_next,
  output gbsp_pkg::result_t result
);

  // Colour table length: three bytes per entry, 2^(size+1) entries.
  function automatic logic [9:0] table_len(input logic [7:0] flags);
    logic [10:0] len;
    len = 11'd3 << ({1'b0, flags[2:0]} + 4'd1);
    return len[9:0];
  endfunction

  gbsp_pkg::state_t cur;
  logic [7:0]       flags;
  logic [9:0]       clamped;

  always_comb begin
    cur        = restart ? gbsp_pkg::STATE_RESET : state;
    state_next = cur;
    flags      = cur.held_flags;
    clamped    = (cur.count > gbsp_pkg::OFFSET_LIMIT) ? gbsp_pkg::OFFSET_LIMIT : cur.count;

    result.byte_out          = data_byte;
    result.offset_in_section = cur.count;
    result.end_of_file       = 1'b0;
    result.section           = gbsp_pkg::SEC_AFTER;

    unique case (cur.phase)
      gbsp_pkg::PH_SIG: begin
        result.section = gbsp_pkg::SEC_SIG;
        if (cur.count >= 10'd5) begin
          state_next.phase = gbsp_pkg::PH_SCREEN;
          state_next.count = 10'd0;
        end else begin
          state_next.count = cur.count + 10'd1;
        end
      end
      gbsp_pkg::PH_SCREEN: begin
        result.section = gbsp_pkg::SEC_SCREEN;
        if (cur.count == 10'd4) begin
          flags = data_byte;
        end
        state_next.held_flags = flags;
        if (cur.count >= 10'd6) begin
          state_next.count = 10'd0;
          if (flags[gbsp_pkg::TABLE_FLAG_BIT]) begin
            state_next.table_bytes = table_len(flags);
            state_next.phase       = gbsp_pkg::PH_GTABLE;
          end else begin
            state_next.phase = gbsp_pkg::PH_SEP;
          end
        end else begin
          state_next.count = cur.count + 10'd1;
        end
      end
      gbsp_pkg::PH_GTABLE, gbsp_pkg::PH_LTABLE: begin
        result.section = (cur.phase == gbsp_pkg::PH_GTABLE) ?
                         gbsp_pkg::SEC_GTABLE : gbsp_pkg::SEC_LTABLE;
        if (({1'b0, cur.count} + 11'd1) >= {1'b0, cur.table_bytes}) begin
          state_next.phase = (cur.phase == gbsp_pkg::PH_GTABLE) ?
                             gbsp_pkg::PH_SEP : gbsp_pkg::PH_CODESIZE;
          state_next.count = 10'd0;
        end else begin
          state_next.count = cur.count + 10'd1;
        end
      end
      gbsp_pkg::PH_SEP: begin
        state_next.count = 10'd0;
        if (data_byte == gbsp_pkg::TRAILER_BYTE) begin
          result.section     = gbsp_pkg::SEC_TRAILER;
          result.end_of_file = 1'b1;
          state_next.phase   = gbsp_pkg::PH_AFTER;
        end else begin
          result.section   = gbsp_pkg::SEC_SEP;
          state_next.phase = gbsp_pkg::PH_IMGDESC;
        end
      end
      gbsp_pkg::PH_IMGDESC: begin
        result.section = gbsp_pkg::SEC_IMGDESC;
        if (cur.count >= 10'd8) begin
          state_next.held_flags = data_byte;
          state_next.count      = 10'd0;
          if (data_byte[gbsp_pkg::TABLE_FLAG_BIT]) begin
            state_next.table_bytes = table_len(data_byte);
            state_next.phase       = gbsp_pkg::PH_LTABLE;
          end else begin
            state_next.phase = gbsp_pkg::PH_CODESIZE;
          end
        end else begin
          state_next.count = cur.count + 10'd1;
        end
      end
      gbsp_pkg::PH_CODESIZE: begin
        result.section   = gbsp_pkg::SEC_CODESIZE;
        state_next.phase = gbsp_pkg::PH_BLKLEN;
        state_next.count = 10'd0;
      end
      gbsp_pkg::PH_BLKLEN: begin
        result.section             = gbsp_pkg::SEC_BLKLEN;
        state_next.block_remaining = data_byte;
        state_next.count           = 10'd0;
        state_next.phase = (data_byte == 8'd0) ? gbsp_pkg::PH_SEP : gbsp_pkg::PH_BLKDATA;
      end
      gbsp_pkg::PH_BLKDATA: begin
        result.section = gbsp_pkg::SEC_BLKDATA;
        if (cur.block_remaining <= 8'd1) begin
          state_next.block_remaining = 8'd0;
          state_next.count           = 10'd0;
          state_next.phase           = gbsp_pkg::PH_BLKLEN;
        end else begin
          state_next.block_remaining = cur.block_remaining - 8'd1;
          state_next.count           = cur.count + 10'd1;
        end
      end
      default: begin
        // After the trailer, and any phase code that means nothing.
        result.section           = gbsp_pkg::SEC_AFTER;
        result.offset_in_section = clamped;
        state_next.phase         = gbsp_pkg::PH_AFTER;
        state_next.count = (clamped < gbsp_pkg::OFFSET_LIMIT) ? clamped + 10'd1 : clamped;
      end
    endcase
  end

endmodule

// File: sv/gbsp_out_stage.sv
// ----------------------------------------------------------------------------
// gbsp_out_stage: result register of the parser
// Holds one tagged word until the receiver takes it, and reports whether a
// new word can be loaded in this cycle.
// ----------------------------------------------------------------------------
module gbsp_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  gbsp_pkg::result_t  result,
  output logic               space,
  gbsp_out_if.source         tag_chan
);

  logic              valid;
  gbsp_pkg::result_t held;

  assign space = !valid || tag_chan.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (tag_chan.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign tag_chan.valid             = valid;
  assign tag_chan.byte_out          = held.byte_out;
  assign tag_chan.section           = held.section;
  assign tag_chan.offset_in_section = held.offset_in_section;
  assign tag_chan.end_of_file       = held.end_of_file;

endmodule

// File: sv/gif_block_structure_parser.sv
// ----------------------------------------------------------------------------
// gif_block_structure_parser: tags each byte of a GIF stream with its section
// Follows the container structure of a GIF file byte by byte and reports,
// for every byte, the section it lies in and its offset there.
// ----------------------------------------------------------------------------
// Use: bytes of the file arrive on byte_chan, one word per handshake, with
// restart set on the first byte of each new file. Every accepted word yields
// exactly one word on tag_chan: the byte itself, its section code, its offset
// within that section and an end-of-file flag that is set on the trailer.
// A word accepted on byte_chan is offered on tag_chan in the cycle after it
// is taken. Throughput is one word per cycle while tag_chan is not stalled,
// set by the single result register; the parser state advances in the same
// cycle as the byte is taken, so consecutive bytes need no gap.
// When the receiver stalls, the result register holds its word and
// byte_chan.ready stays high only while that word is being taken in the
// same cycle, so nothing is dropped or repeated.
// A synchronous reset puts the parser at the first byte of the signature
// and empties the result register; restart does the same for the parser
// state, in line with the byte that carries it.
// ----------------------------------------------------------------------------
module gif_block_structure_parser (
  input  logic        clk,
  input  logic        rst,
  gbsp_in_if.sink     byte_chan,
  gbsp_out_if.source  tag_chan
);

  // Parser state: phase, offset counter, colour table length, the last
  // packed flags byte and the bytes left in the current sub-block.
  gbsp_pkg::state_t  state;
  gbsp_pkg::state_t  state_next;
  gbsp_pkg::result_t result;
  logic              space;
  logic              accept;

  assign byte_chan.ready = space;
  assign accept          = byte_chan.valid && space;

  // All the structure tracking for one byte is a single combinational step.
  gbsp_tagger u_tagger (
    .state      (state),
    .data_byte  (byte_chan.data_byte),
    .restart    (byte_chan.restart),
    .state_next (state_next),
    .result     (result)
  );

  // The state moves on only when a byte is actually accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbsp_pkg::STATE_RESET;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // The tagged word waits here until the receiver takes it.
  gbsp_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .result   (result),
    .space    (space),
    .tag_chan (tag_chan)
  );

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the GIF block structure parser
// Feeds well-formed GIF streams with random content, truncated files and
// stray bytes into the parser. A built-in tagger in the testbench tracks the
// container structure itself, and every tagged word from the parser is
// checked against it field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Bytes in one colour table entry (red, green, blue).
  localparam int unsigned COLOUR_ENTRY_BYTES = 3;
  // Separator that introduces an image descriptor in a real file.
  localparam logic [7:0] IMAGE_SEPARATOR = 8'h2C;
  // Once fewer than this many bytes are left to send, both sides stop idling.
  localparam int unsigned CALM_TAIL = 150;
  // Number of checked words after which the receiver holds off for a while.
  localparam int unsigned LONG_HOLD_AT = 300;
  localparam int unsigned LONG_HOLD_CYCLES = 64;
  localparam int unsigned RANDOM_BYTES = 670;

  // One byte waiting to be offered, with its restart mark. A set drain_first
  // makes the sender wait until every tagged word so far has come back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
    logic       drain_first;
  } stream_byte_t;

  logic clk;
  logic rst;

  gbsp_in_if  byte_if ();
  gbsp_out_if tag_if ();

  gif_block_structure_parser DUT (
    .clk       (clk),
    .rst       (rst),
    .byte_chan (byte_if),
    .tag_chan  (tag_if)
  );

  stream_byte_t      gif_stream[$];    // bytes still to be offered
  gbsp_pkg::result_t pending_tags[$];  // tags worked out for accepted bytes
  int unsigned  bytes_queued;
  int unsigned  bytes_accepted = 0;
  int unsigned  tags_checked = 0;
  int unsigned  tag_errors = 0;
  logic         byte_taken = 1'b0;

  // Sender and receiver idle counters.
  int unsigned  send_gap_left = 0;
  int unsigned  recv_stall_left = 0;
  int unsigned  long_hold_left = 0;
  bit           long_hold_done = 1'b0;

  // The testbench's own copy of the parser state. The phase holds the same
  // codes as the section field; it never rests on the trailer code.
  logic [3:0] parse_phase  = gbsp_pkg::SEC_SIG;
  logic [9:0] parse_count  = '0;
  logic [9:0] table_len    = '0;
  logic [7:0] packed_flags = '0;
  logic [7:0] blk_left     = '0;

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Every input is given a known value at time zero. Reset is released on a
  // falling edge with a nonblocking write, so the driver sees a clean change.
  initial begin
    rst = 1'b1;
    byte_if.valid = 1'b0;
    byte_if.data_byte = '0;
    byte_if.restart = 1'b0;
    tag_if.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Tag prediction
  // --------------------------------------------------------------------------

  // After a packed byte: go to the colour table if its flag is set, and
  // otherwise straight on to the section that follows it.
  function automatic void open_table_or(input logic [3:0] table_sec,
                                        input logic [3:0] next_sec);
    parse_count = '0;
    if (packed_flags[gbsp_pkg::TABLE_FLAG_BIT]) begin
      table_len = 10'(COLOUR_ENTRY_BYTES << (packed_flags[2:0] + 1));
      parse_phase = table_sec;
    end else begin
      parse_phase = next_sec;
    end
  endfunction

  // Tags one accepted byte and moves the state on, exactly as the parser
  // should. A restart clears the whole state before the byte is looked at.
  function automatic gbsp_pkg::result_t tag_byte(input logic [7:0] b,
                                                 input logic restart);
    gbsp_pkg::result_t t;
    if (restart) begin
      parse_phase  = gbsp_pkg::SEC_SIG;
      parse_count  = '0;
      table_len    = '0;
      packed_flags = '0;
      blk_left     = '0;
    end
    t.byte_out = b;
    t.section = parse_phase;
    t.offset_in_section = parse_count;
    t.end_of_file = 1'b0;
    case (parse_phase)
      gbsp_pkg::SEC_SIG: begin
        if (parse_count >= 10'd5) begin
          parse_phase = gbsp_pkg::SEC_SCREEN;
          parse_count = '0;
        end else begin
          parse_count++;
        end
      end
      gbsp_pkg::SEC_SCREEN: begin
        // The packed byte of the screen descriptor sits at offset 4.
        if (parse_count == 10'd4) packed_flags = b;
        if (parse_count >= 10'd6) open_table_or(gbsp_pkg::SEC_GTABLE, gbsp_pkg::SEC_SEP);
        else parse_count++;
      end
      gbsp_pkg::SEC_GTABLE, gbsp_pkg::SEC_LTABLE: begin
        if (int'(parse_count) + 1 >= int'(table_len)) begin
          parse_phase = (parse_phase == gbsp_pkg::SEC_GTABLE) ?
                        gbsp_pkg::SEC_SEP : gbsp_pkg::SEC_CODESIZE;
          parse_count = '0;
        end else begin
          parse_count++;
        end
      end
      gbsp_pkg::SEC_SEP: begin
        // Only the trailer value ends the file; any other value, an
        // extension introducer included, is taken as an image separator.
        parse_count = '0;
        if (b == gbsp_pkg::TRAILER_BYTE) begin
          t.section = gbsp_pkg::SEC_TRAILER;
          t.end_of_file = 1'b1;
          parse_phase = gbsp_pkg::SEC_AFTER;
        end else begin
          parse_phase = gbsp_pkg::SEC_IMGDESC;
        end
      end
      gbsp_pkg::SEC_IMGDESC: begin
        // The image descriptor's packed byte is its last, at offset 8.
        if (parse_count >= 10'd8) begin
          packed_flags = b;
          open_table_or(gbsp_pkg::SEC_LTABLE, gbsp_pkg::SEC_CODESIZE);
        end else begin
          parse_count++;
        end
      end
      gbsp_pkg::SEC_CODESIZE: begin
        parse_phase = gbsp_pkg::SEC_BLKLEN;
        parse_count = '0;
      end
      gbsp_pkg::SEC_BLKLEN: begin
        // A zero length closes the image data.
        blk_left = b;
        parse_count = '0;
        parse_phase = (b == 8'd0) ? gbsp_pkg::SEC_SEP : gbsp_pkg::SEC_BLKDATA;
      end
      gbsp_pkg::SEC_BLKDATA: begin
        if (blk_left <= 8'd1) begin
          blk_left = '0;
          parse_count = '0;
          parse_phase = gbsp_pkg::SEC_BLKLEN;
        end else begin
          blk_left--;
          parse_count++;
        end
      end
      default: begin
        // Past the trailer the offset counts up and then sticks at its limit.
        t.section = gbsp_pkg::SEC_AFTER;
        parse_phase = gbsp_pkg::SEC_AFTER;
        if (parse_count > gbsp_pkg::OFFSET_LIMIT) parse_count = gbsp_pkg::OFFSET_LIMIT;
        t.offset_in_section = parse_count;
        if (parse_count < gbsp_pkg::OFFSET_LIMIT) parse_count++;
      end
    endcase
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b, input logic restart,
                            input logic drain_first);
    stream_byte_t s;
    s.data_byte = b;
    s.restart = restart;
    s.drain_first = drain_first;
    gif_stream.push_back(s);
  endtask

  // Builds one GIF file with random content and queues it, or only its first
  // keep bytes when keep is non-zero. A huge file carries a large global
  // table and a full 255-byte sub-block; every file ends with tail_len stray
  // bytes after the trailer.
  task automatic queue_gif_file(input bit huge, input int tail_len, input int keep,
                                input bit drain);
    logic [7:0] fb[$];
    logic [7:0] pk;
    logic [7:0] sep;
    int n_img;
    int n_blk;
    int len;
    int n_out;
    for (int i = 0; i < 6; i++) fb.push_back(8'($urandom));
    pk = 8'($urandom);
    pk[2:0] = 3'($urandom_range(0, 2));
    if (huge) pk = {1'b1, pk[6:3], 3'd5};
    for (int i = 0; i < 7; i++) fb.push_back((i == 4) ? pk : 8'($urandom));
    if (pk[gbsp_pkg::TABLE_FLAG_BIT])
      repeat (COLOUR_ENTRY_BYTES << (pk[2:0] + 1)) fb.push_back(8'($urandom));
    n_img = huge ? 1 : $urandom_range(0, 3);
    for (int m = 0; m < n_img; m++) begin
      if ($urandom_range(0, 3) == 0) begin
        do sep = 8'($urandom); while (sep == gbsp_pkg::TRAILER_BYTE);
      end else begin
        sep = IMAGE_SEPARATOR;
      end
      fb.push_back(sep);
      pk = 8'($urandom);
      pk[2:0] = 3'($urandom_range(0, 2));
      pk[gbsp_pkg::TABLE_FLAG_BIT] = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < 9; i++) fb.push_back((i == 8) ? pk : 8'($urandom));
      if (pk[gbsp_pkg::TABLE_FLAG_BIT])
        repeat (COLOUR_ENTRY_BYTES << (pk[2:0] + 1)) fb.push_back(8'($urandom));
      fb.push_back(8'($urandom));  // LZW code size
      n_blk = huge ? 2 : $urandom_range(0, 3);
      for (int k = 0; k < n_blk; k++) begin
        len = (huge && k == 0) ? 255 : $urandom_range(1, 16);
        fb.push_back(8'(len));
        repeat (len) fb.push_back(8'($urandom));
      end
      fb.push_back(8'd0);
    end
    fb.push_back(gbsp_pkg::TRAILER_BYTE);
    repeat (tail_len) fb.push_back(8'($urandom));
    n_out = (keep > 0 && keep < fb.size()) ? keep : fb.size();
    for (int i = 0; i < n_out; i++) queue_byte(fb[i], i == 0, drain && i == 0);
  endtask

  // Stray bytes, sometimes continuing the current file, with the odd restart
  // scattered through them.
  task automatic queue_noise(input int n);
    for (int i = 0; i < n; i++)
      queue_byte(8'($urandom), (i == 0) ? 1'($urandom) : ($urandom_range(0, 15) == 0),
                 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Sender: offers the next byte at each falling edge once the last word has
  // gone, with random gaps while plenty of stimulus remains.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    stream_byte_t nxt;
    if (rst) begin
      byte_if.valid <= 1'b0;
    end else if (!byte_if.valid || byte_taken) begin
      if (send_gap_left > 0) begin
        send_gap_left--;
        byte_if.valid <= 1'b0;
      end else if (gif_stream.size() == 0) begin
        byte_if.valid <= 1'b0;
      end else if (gif_stream[0].drain_first && pending_tags.size() != 0) begin
        // Hold the next file back until the parser has handed over every word.
        byte_if.valid <= 1'b0;
      end else if (gif_stream.size() >= CALM_TAIL && $urandom_range(0, 9) == 0) begin
        send_gap_left = $urandom_range(1, 8) - 1;
        byte_if.valid <= 1'b0;
      end else begin
        nxt = gif_stream.pop_front();
        byte_if.valid <= 1'b1;
        byte_if.data_byte <= nxt.data_byte;
        byte_if.restart <= nxt.restart;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off counted here so that the
  // result register fills and the parser has to refuse input.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      tag_if.ready <= 1'b0;
    end else if (long_hold_left > 0) begin
      long_hold_left--;
      tag_if.ready <= 1'b0;
    end else if (!long_hold_done && tags_checked >= LONG_HOLD_AT) begin
      long_hold_done = 1'b1;
      long_hold_left = LONG_HOLD_CYCLES - 1;
      tag_if.ready <= 1'b0;
    end else if (recv_stall_left > 0) begin
      recv_stall_left--;
      tag_if.ready <= 1'b0;
    end else if (gif_stream.size() >= CALM_TAIL && $urandom_range(0, 9) == 0) begin
      recv_stall_left = $urandom_range(1, 8) - 1;
      tag_if.ready <= 1'b0;
    end else begin
      tag_if.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: at each rising edge checks a delivered word against the oldest
  // predicted tag, then records a byte accepted at the same edge. Checking
  // comes first so that a stray word can never consume the new prediction.
  // --------------------------------------------------------------------------
  task automatic report_tag_error(input string msg);
    if (tag_errors < 40) $display("tb_top: word %0d: %s", tags_checked, msg);
    tag_errors++;
  endtask

  always @(posedge clk) begin
    gbsp_pkg::result_t want;
    if (!rst && tag_if.valid && tag_if.ready) begin
      if (pending_tags.size() == 0) begin
        report_tag_error("tagged word with no byte waiting for it");
      end else begin
        want = pending_tags.pop_front();
        if (tag_if.byte_out !== want.byte_out)
          report_tag_error($sformatf("byte_out %0h, should be %0h",
                                     tag_if.byte_out, want.byte_out));
        if (tag_if.section !== want.section)
          report_tag_error($sformatf("section %0d, should be %0d",
                                     tag_if.section, want.section));
        if (tag_if.offset_in_section !== want.offset_in_section)
          report_tag_error($sformatf("offset_in_section %0d, should be %0d",
                                     tag_if.offset_in_section, want.offset_in_section));
        if (tag_if.end_of_file !== want.end_of_file)
          report_tag_error($sformatf("end_of_file %0b, should be %0b",
                                     tag_if.end_of_file, want.end_of_file));
      end
      tags_checked++;
    end
    byte_taken <= !rst && byte_if.valid && byte_if.ready;
    if (!rst && byte_if.valid && byte_if.ready) begin
      pending_tags.push_back(tag_byte(byte_if.data_byte, byte_if.restart));
      bytes_accepted++;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned random_start;
    int unsigned files;
    int unsigned pick;

    // Directed file: extreme byte values in the signature, no global table,
    // an extension introducer taken as an image, a short sub-block, the zero
    // terminator, the trailer, and a trailer value arriving after the trailer.
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'h47, 1'b0, 1'b0);
    queue_byte(8'h49, 1'b0, 1'b0);
    queue_byte(8'h46, 1'b0, 1'b0);
    queue_byte(8'h38, 1'b0, 1'b0);
    for (int i = 0; i < 7; i++) queue_byte((i == 0) ? 8'hFF : 8'h00, 1'b0, 1'b0);
    queue_byte(8'h21, 1'b0, 1'b0);
    for (int i = 0; i < 9; i++) queue_byte((i == 4) ? 8'h01 : 8'h00, 1'b0, 1'b0);
    queue_byte(8'h08, 1'b0, 1'b0);
    queue_byte(8'h02, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(gbsp_pkg::TRAILER_BYTE, 1'b0, 1'b0);
    queue_byte(gbsp_pkg::TRAILER_BYTE, 1'b0, 1'b0);

    // Random part: mostly complete files, some cut short, some stray bytes.
    // The second file waits for the parser to drain, and the fourth is a
    // huge one.
    random_start = gif_stream.size();
    files = 0;
    while (gif_stream.size() - random_start < RANDOM_BYTES) begin
      pick = $urandom_range(0, 9);
      if (files == 3) begin
        queue_gif_file(1'b1, 40, 0, 1'b0);
      end else if (files == 1) begin
        queue_gif_file(1'b0, 2, 0, 1'b1);
      end else if (pick < 6) begin
        queue_gif_file(1'b0, $urandom_range(0, 3), 0, 1'b0);
      end else if (pick < 8) begin
        queue_gif_file(1'b0, 0, $urandom_range(1, 40), 1'b0);
      end else begin
        queue_noise($urandom_range(4, 30));
      end
      files++;
    end
    bytes_queued = gif_stream.size();

    do @(posedge clk); while (bytes_accepted != bytes_queued);
    do @(posedge clk); while (pending_tags.size() != 0);
    repeat (4) @(posedge clk);
    if (tag_errors == 0 && pending_tags.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// File: gif_block_structure_parser.f
sv/gbsp_pkg.sv
sv/gbsp_in_if.sv
sv/gbsp_out_if.sv
sv/gbsp_tagger.sv
sv/gbsp_out_stage.sv
sv/gif_block_structure_parser.sv
sim/tb_top.sv
